[hw/rtl/fsks_pkg.sv]
// Package with the shared types, codes and helpers of the fixed-slot key/value store.
`timescale 1ns / 1ps

package fsks_pkg;

    // Default sizes of the store.
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_VALUE_BYTES = 8;
    localparam int DEF_ENTRIES     = 16;

    // Fixed widths of the port fields.
    localparam int FIELD_W  = 64;
    localparam int LEN_W    = 4;
    localparam int IN_LEN_W = 8;

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_WIPE = 2'd2,
        CMD_RSVD = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    // Mask that keeps the low n bytes of a word.
    function automatic logic [FIELD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [FIELD_W-1:0] m;
        m = '0;
        for (int j = 0; j < FIELD_W / 8; j++) begin
            if (LEN_W'(j) < n) begin
                m[8*j +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

[hw/rtl/fsks_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module fsks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fixed_slot_key_value_store.sv]
// Top level of the fixed-slot key/value store with a linear record search.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------------
//  command  | i_in_valid / o_in_ready   | i_cmd, i_key, i_value_in, i_length
//  result   | o_out_valid / i_out_ready | o_status, o_value_out, o_length_out
//
// A set or get word is taken in, then the search reads the filled records in turn
// through the single read port of the record RAM. The read is registered, so each
// record is compared while the next one is read, and a miss is decided once all are
// compared; the result is then handed to the output register. Wipe words, invalid
// words and the reserved command skip the search. The reset clears only the control
// state and the record count; the RAM needs no clearing pass, as only records below
// the count are ever read. A stalled result waits in the output register while the
// next word is taken in and searched; the block holds in its last step only when a
// second result is ready before the first one has been taken.
`timescale 1ns / 1ps

module fixed_slot_key_value_store
    import fsks_pkg::*;
#(
    parameter int KEY_BYTES   = DEF_KEY_BYTES,
    parameter int VALUE_BYTES = DEF_VALUE_BYTES,
    parameter int ENTRIES     = DEF_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_cmd,
    input  logic [FIELD_W-1:0]  i_key,
    input  logic [FIELD_W-1:0]  i_value_in,
    input  logic [IN_LEN_W-1:0] i_length,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output logic [FIELD_W-1:0]  o_value_out,
    output logic [LEN_W-1:0]    o_length_out
);

    // Record layout in the RAM: {key, length, value}.
    localparam int KW    = 8 * KEY_BYTES;
    localparam int VW    = 8 * VALUE_BYTES;
    localparam int REC_W = KW + LEN_W + VW;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [CNT_W-1:0]    ENTRIES_C = CNT_W'(ENTRIES);
    localparam logic [IN_LEN_W-1:0] VB_LEN    = IN_LEN_W'(VALUE_BYTES);

    t_state r_state, n_state;

    // Latched command word.
    t_cmd             r_cmd;
    logic [KW-1:0]    r_key_norm;
    logic [VW-1:0]    r_val;
    logic [LEN_W-1:0] r_len;

    // Search control.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic             r_pend;
    logic [IDX_W-1:0] r_cmp_idx;

    // Result waiting for the output register, and the output register itself.
    t_status          r_res_status;
    logic [FIELD_W-1:0] r_res_value;
    logic [LEN_W-1:0] r_res_len;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [FIELD_W-1:0] r_out_value;
    logic [LEN_W-1:0] r_out_len;

    // Decode of the incoming word.
    t_cmd             w_cmd;
    logic [2:0]       w_term_pos;
    logic             w_key_ok;
    logic [KW-1:0]    w_key_norm;
    logic             w_len_nz;
    logic             w_len_le;
    logic             w_set_ok;
    logic             w_get_ok;
    logic [FIELD_W-1:0] w_in_mask;

    // RAM interface.
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [REC_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [REC_W-1:0] w_rdata;
    logic [KW-1:0]    w_rd_key;
    logic [LEN_W-1:0] w_rd_len;
    logic [VW-1:0]    w_rd_val;

    // Search decisions and handshakes.
    logic             w_accept;
    logic             w_hit;
    logic             w_miss;
    logic             w_done;
    logic             w_issue;
    logic             w_trunc;
    logic [FIELD_W-1:0] w_get_mask;
    logic             w_load_out;

    assign w_cmd = t_cmd'(i_cmd);

    // A key ends at its first zero byte; without one among the key bytes it is invalid.
    always_comb begin
        w_key_ok   = 1'b0;
        w_term_pos = '0;
        for (int i = KEY_BYTES - 1; i >= 0; i--) begin
            if (i_key[8*i +: 8] == 8'h00) begin
                w_key_ok   = 1'b1;
                w_term_pos = 3'(i);
            end
        end
        w_key_norm = '0;
        for (int j = 0; j < KEY_BYTES; j++) begin
            if (3'(j) < w_term_pos) begin
                w_key_norm[8*j +: 8] = i_key[8*j +: 8];
            end
        end
    end

    assign w_len_nz  = (i_length != '0);
    assign w_len_le  = (i_length <= VB_LEN);
    assign w_set_ok  = (w_cmd == CMD_SET) && w_len_nz && w_len_le && w_key_ok;
    assign w_get_ok  = (w_cmd == CMD_GET) && w_len_le && w_key_ok;
    assign w_in_mask = byte_mask(i_length[LEN_W-1:0]);

    assign w_rd_key = w_rdata[REC_W-1 -: KW];
    assign w_rd_len = w_rdata[VW +: LEN_W];
    assign w_rd_val = w_rdata[VW-1:0];

    fsks_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_records (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (w_set_ok || w_get_ok) ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH: begin
                if (w_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the state machine: handshakes, search steps and RAM accesses.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_accept   = o_in_ready && i_in_valid;
        w_hit      = (r_state == S_SEARCH) && r_pend && (w_rd_key == r_key_norm);
        w_miss     = (r_state == S_SEARCH) && !r_pend && (r_ptr >= r_count);
        w_done     = w_hit || w_miss;
        w_issue    = (r_state == S_SEARCH) && !w_done && (r_ptr < r_count);
        w_load_out = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
        w_raddr    = r_ptr[IDX_W-1:0];

        // A set writes the matching slot, or appends when there is room.
        w_we    = 1'b0;
        w_waddr = r_cmp_idx;
        w_wdata = {r_key_norm, r_len, r_val};
        if (r_cmd == CMD_SET) begin
            if (w_hit) begin
                w_we = 1'b1;
            end else if (w_miss && (r_count < ENTRIES_C)) begin
                w_we    = 1'b1;
                w_waddr = r_count[IDX_W-1:0];
            end
        end

        w_trunc    = (r_len < w_rd_len);
        w_get_mask = byte_mask(w_trunc ? r_len : w_rd_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_issue;
            if (w_accept) begin
                r_ptr <= '0;
            end else if (w_issue) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (w_accept && (w_cmd == CMD_WIPE)) begin
                r_count <= '0;
            end else if (w_miss && (r_cmd == CMD_SET) && (r_count < ENTRIES_C)) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= w_cmd;
            r_key_norm <= w_key_norm;
            r_val      <= i_value_in[VW-1:0] & w_in_mask[VW-1:0];
            r_len      <= i_length[LEN_W-1:0];
            // Words that need no search get their answer right away.
            r_res_status <= (w_cmd == CMD_WIPE) ? ST_OK : ST_INVALID;
            r_res_value  <= '0;
            r_res_len    <= '0;
        end
        if (w_issue) begin
            r_cmp_idx <= r_ptr[IDX_W-1:0];
        end
        if (w_done) begin
            r_res_value <= '0;
            r_res_len   <= '0;
            if (r_cmd == CMD_SET) begin
                r_res_status <= (w_miss && (r_count >= ENTRIES_C)) ? ST_FULL : ST_OK;
            end else if (w_miss) begin
                r_res_status <= ST_NOT_FOUND;
            end else begin
                r_res_status <= w_trunc ? ST_TRUNCATED : ST_OK;
                r_res_value  <= FIELD_W'(w_rd_val & w_get_mask[VW-1:0]);
                r_res_len    <= w_trunc ? r_len : w_rd_len;
            end
        end
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_len    <= r_res_len;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_value_out  = r_out_value;
    assign o_length_out = r_out_len;

endmodule
